### rtl/arxbc_pkg.sv
package arxbc_pkg;

    localparam int ROUNDS_PER_HALF = 10;
    // two pipeline stages per round, two halves
    localparam int NUM_STAGES      = 4 * ROUNDS_PER_HALF;

    localparam int NUM_KEY_REGS    = 6;
    localparam int KEY_IDX_W       = 3;
    localparam int PADDR_W         = 6;
    localparam int PDATA_W         = 64;

    localparam logic [1:0] MODE_WHITEN = 2'd0;
    localparam logic [1:0] MODE_LO     = 2'd1;
    localparam logic [1:0] MODE_HI     = 2'd2;

    typedef logic [31:0] t_word;
    typedef t_word [3:0] t_block;
    typedef logic [NUM_KEY_REGS-1:0][PDATA_W-1:0] t_key_regs;

    function automatic t_word rotl(input t_word v, input logic [4:0] r);
        return (v << r) | (v >> (6'd32 - {1'b0, r}));
    endfunction

    function automatic t_word mix(input t_word x, input t_word y, input t_word z,
                                  input t_word w, input logic [4:0] r);
        t_word s;
        s = x + y;
        return (rotl(s, r) ^ z) + w;
    endfunction

endpackage

### rtl/arxbc_cfg.sv
module arxbc_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [arxbc_pkg::PADDR_W-1:0]        paddr,
    input  logic [arxbc_pkg::PDATA_W-1:0]        pwdata,
    output logic [arxbc_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready,
    output arxbc_pkg::t_key_regs                 o_keys
);

    arxbc_pkg::t_key_regs                r_keys;
    logic [arxbc_pkg::KEY_IDX_W-1:0]     idx;
    logic                                idx_ok;

    assign idx    = paddr[arxbc_pkg::PADDR_W-1:3];
    assign idx_ok = idx < arxbc_pkg::KEY_IDX_W'(arxbc_pkg::NUM_KEY_REGS);
    assign pready = 1'b1;
    assign o_keys = r_keys;
    assign prdata = idx_ok ? r_keys[idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (psel && penable && pwrite && idx_ok) begin
            r_keys[idx] <= pwdata;
        end
    end

endmodule

### rtl/arxbc_stage.sv
module arxbc_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ld,
    input  logic                i_vld,
    input  arxbc_pkg::t_block   i_w,
    input  logic [1:0]          i_mode,
    input  logic                i_whiten,
    input  arxbc_pkg::t_block   i_key,
    output logic                o_vld,
    output arxbc_pkg::t_block   o_w
);

    logic               r_vld;
    arxbc_pkg::t_block  r_w;
    arxbc_pkg::t_block  f;
    arxbc_pkg::t_block  n_w;
    arxbc_pkg::t_word   x2;
    arxbc_pkg::t_word   x3;

    always_comb begin
        f  = i_w;
        x2 = arxbc_pkg::mix(i_w[2], i_w[3], i_w[0], i_w[1], 5'd3);
        x3 = arxbc_pkg::mix(i_w[3], i_w[0], i_w[1], x2, 5'd4);
        unique case (i_mode)
            arxbc_pkg::MODE_LO: begin
                f[0] = arxbc_pkg::mix(i_w[0], i_w[1], i_w[2], i_w[3], 5'd1);
                f[1] = arxbc_pkg::mix(i_w[1], i_w[2], i_w[3], f[0], 5'd2);
            end
            arxbc_pkg::MODE_HI: begin
                f[1] = arxbc_pkg::rotl(i_w[1], 5'd8);
                f[2] = arxbc_pkg::rotl(x2, 5'd16);
                f[3] = arxbc_pkg::rotl(x3, 5'd24);
            end
            default: begin
                f = i_w;
            end
        endcase
        n_w = i_whiten ? (f ^ i_key) : f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_w <= n_w;
        end
    end

    assign o_vld = r_vld;
    assign o_w   = r_w;

endmodule

### rtl/arx_block_cipher_encrypt.sv
// Throughput: one block per cycle unless the output stalls; one register stage
// per half round; the first stage whitens, the last is the output register.
// Stalls propagate back through per-stage valid bits; bubbles are squeezed.
// Reset (synchronous, active low) clears all valid bits and the key registers.
module arx_block_cipher_encrypt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arxbc_pkg::PADDR_W-1:0]    paddr,
    input  logic [arxbc_pkg::PDATA_W-1:0]    pwdata,
    output logic [arxbc_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [31:0]                      i_plain_word_0,
    input  logic [31:0]                      i_plain_word_1,
    input  logic [31:0]                      i_plain_word_2,
    input  logic [31:0]                      i_plain_word_3,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_cipher_word_0,
    output logic [31:0]                      o_cipher_word_1,
    output logic [31:0]                      o_cipher_word_2,
    output logic [31:0]                      o_cipher_word_3
);

    localparam int S = arxbc_pkg::NUM_STAGES;

    arxbc_pkg::t_key_regs       keys;
    arxbc_pkg::t_block [2:0]    grp;
    arxbc_pkg::t_block [S:0]    w;
    logic [S:0]                 vld;
    logic [S+1:0]               ld;
    arxbc_pkg::t_block          w_in;

    arxbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (keys)
    );

    for (genvar g = 0; g < 3; g++) begin : g_grp
        for (genvar j = 0; j < 4; j++) begin : g_word
            localparam int KW = 4 * g + j;
            assign grp[g][j] = keys[KW / 2][(KW % 2) * 32 +: 32];
        end
    end

    assign w_in = {i_plain_word_3, i_plain_word_2, i_plain_word_1, i_plain_word_0};

    assign ld[S+1] = i_ready;
    for (genvar k = 0; k <= S; k++) begin : g_stage
        localparam logic [1:0] MODE = (k == 0) ? arxbc_pkg::MODE_WHITEN :
                                      (((k - 1) % 2) == 0) ? arxbc_pkg::MODE_LO :
                                                             arxbc_pkg::MODE_HI;
        localparam logic WHITEN = (k == 0) || (k == S / 2) || (k == S);
        localparam int   GROUP  = (k == 0) ? 0 : ((k == S / 2) ? 1 : 2);

        assign ld[k] = !vld[k] || ld[k+1];

        arxbc_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ld     (ld[k]),
            .i_vld    ((k == 0) ? i_valid : vld[(k == 0) ? 0 : k - 1]),
            .i_w      ((k == 0) ? w_in : w[(k == 0) ? 0 : k - 1]),
            .i_mode   (MODE),
            .i_whiten (WHITEN),
            .i_key    (grp[GROUP]),
            .o_vld    (vld[k]),
            .o_w      (w[k])
        );
    end

    assign o_ready         = ld[0];
    assign o_valid         = vld[S];
    assign o_cipher_word_0 = w[S][0];
    assign o_cipher_word_1 = w[S][1];
    assign o_cipher_word_2 = w[S][2];
    assign o_cipher_word_3 = w[S][3];

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import arxbc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 8;
    localparam int KEY_WORDS    = 2 * NUM_KEY_REGS;
    localparam int MAX_REPORTS  = 10;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [PADDR_W-1:0] paddr           = '0;
    logic [PDATA_W-1:0] pwdata          = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    t_word              i_plain_word_0  = '0;
    t_word              i_plain_word_1  = '0;
    t_word              i_plain_word_2  = '0;
    t_word              i_plain_word_3  = '0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    t_word              o_cipher_word_0;
    t_word              o_cipher_word_1;
    t_word              o_cipher_word_2;
    t_word              o_cipher_word_3;

    t_word  key_copy [KEY_WORDS];
    t_block cipher_q [$];
    int     mismatch_cnt   = 0;
    int     cycle_cnt      = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     stall_left     = 0;

    arx_block_cipher_encrypt dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_plain_word_0  (i_plain_word_0),
        .i_plain_word_1  (i_plain_word_1),
        .i_plain_word_2  (i_plain_word_2),
        .i_plain_word_3  (i_plain_word_3),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_word_0 (o_cipher_word_0),
        .o_cipher_word_1 (o_cipher_word_1),
        .o_cipher_word_2 (o_cipher_word_2),
        .o_cipher_word_3 (o_cipher_word_3)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_word rol32(t_word v, int unsigned n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

    function automatic t_word mix_word(t_word x, t_word y, t_word z, t_word w,
                                       int unsigned n);
        t_word s;
        s = x + y;
        return (rol32(s, n) ^ z) + w;
    endfunction

    function automatic t_block encrypt_block(t_block p);
        t_block s;
        s = p;
        for (int h = 0; h < 3; h++) begin
            for (int j = 0; j < 4; j++)
                s[j] = s[j] ^ key_copy[4 * h + j];
            if (h < 2) begin
                for (int r = 0; r < ROUNDS_PER_HALF; r++) begin
                    s[0] = mix_word(s[0], s[1], s[2], s[3], 1);
                    s[1] = mix_word(s[1], s[2], s[3], s[0], 2);
                    s[2] = mix_word(s[2], s[3], s[0], s[1], 3);
                    s[3] = mix_word(s[3], s[0], s[1], s[2], 4);
                    s[1] = rol32(s[1], 8);
                    s[2] = rol32(s[2], 16);
                    s[3] = rol32(s[3], 24);
                end
            end
        end
        return s;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, 31);
            3: return ~(t_word'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] rand_key_reg();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : chk
        t_block got;
        t_block want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_cipher_word_3, o_cipher_word_2, o_cipher_word_1, o_cipher_word_0};
            if (cipher_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("tb: unexpected word %h", got);
            end else begin
                want = cipher_q.pop_front();
                for (int j = 0; j < 4; j++) begin
                    if (got[j] !== want[j]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("tb: cipher_word_%0d exp %h got %h", j, want[j], got[j]);
                    end
                end
            end
        end
    end

    task automatic apb_write(int unsigned idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_KEY_REGS) begin
            key_copy[2 * idx]     = data[31:0];
            key_copy[2 * idx + 1] = data[63:32];
        end
        @(posedge i_clk);
    endtask

    task automatic send_block(t_word w0, t_word w1, t_word w2, t_word w3);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_plain_word_0 <= w0;
        i_plain_word_1 <= w1;
        i_plain_word_2 <= w2;
        i_plain_word_3 <= w3;
        do @(posedge i_clk); while (!o_ready);
        cipher_q.push_back(encrypt_block({w3, w2, w1, w0}));
    endtask

    task automatic send_random_block();
        send_block(rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (cipher_q.size() != 0);
    endtask

    task automatic test_zero_key();
        send_block('0, '0, '0, '0);
        send_block('1, '1, '1, '1);
        send_block(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_block(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_block('0, '1, '0, '1);
        send_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        drain();
    endtask

    task automatic test_key_extremes();
        for (int i = 0; i < NUM_KEY_REGS; i++)
            apb_write(i, '1);
        send_block('0, '0, '0, '0);
        send_block('1, '1, '1, '1);
        send_block(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0);
        drain();
        for (int i = 0; i < NUM_KEY_REGS; i++)
            apb_write(i, {32'h8000_0000 >> i, 32'h0000_0001 << i});
        send_block('0, '0, '0, '0);
        send_block('1, '1, '1, '1);
        send_block(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_BABE, 32'h1234_5678);
        drain();
    endtask

    // writes beyond the last key register must leave the key untouched
    task automatic test_key_index_range();
        apb_write(NUM_KEY_REGS, '1);
        apb_write(NUM_KEY_REGS + 1, {$urandom, $urandom});
        send_block('0, '0, '0, '0);
        send_block('1, '1, '1, '1);
        send_block(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
        drain();
    endtask

    task automatic test_random_traffic();
        int idle_pct  [6] = '{0, 10, 30, 60, 20, 5};
        int stall_pct [6] = '{20, 0, 30, 10, 60, 5};
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < NUM_KEY_REGS; i++)
                apb_write(i, rand_key_reg());
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (int k = 0; k < 160; k++) begin
                if (k == 80 && ph % 2 == 0)
                    drain();
                send_random_block();
            end
            drain();
        end
    endtask

    task automatic test_flat_out();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_KEY_REGS; i++)
            apb_write(i, {$urandom, $urandom});
        repeat (240) send_random_block();
        drain();
    endtask

    initial begin
        for (int i = 0; i < KEY_WORDS; i++)
            key_copy[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_key();
        test_key_extremes();
        test_key_index_range();
        test_random_traffic();
        test_flat_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_cnt += cipher_q.size();
        if (mismatch_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
